// File: rtl/ttkt_pkg.sv
// Shared widths, register indexes and reset values for the thresholded top-K tracker.
// No dependencies; the tracker and its checker both import this package.
package ttkt_pkg;

  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned DAY_W    = 48;
  localparam int unsigned RANK_W   = 3;
  localparam int unsigned FOUND_W  = 4;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_START_DAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  // 0.05 as a 16-bit fraction, rounded to nearest.
  localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd3277;

  // One list entry as held in the entry RAM.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [OFF_W-1:0]   offset;
  } entry_t;

  localparam int unsigned ENTRY_W = SCORE_W + OFF_W;

endpackage

// File: rtl/ttkt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the tracker's entry list.
module ttkt_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/thresholded_top_k_tracker.sv
// Thresholded top-K day tracker: keeps the best scoring days of a scan, sorted.
// Depends on ttkt_pkg and on ttkt_ram, which holds the sorted entry list.
//
// Usage: each input item carries the score of the next day (days count from 1)
// and a final_day flag, moved with in_valid_i/in_ready_o. Days scoring below
// score_threshold, or numbered past MAX_DAYS, are not kept. Kept days sit in a
// list of LIST_DEPTH entries in descending score order; ties go behind earlier
// equal scores, and a full list drops a day that does not beat its last entry.
// The item with final_day set is processed first, then the list is read out on
// out_valid_o/out_ready_i, one result per entry from rank 0 (or one empty
// marker), and the list and day count clear for the next scan.
// Timing: after acceptance, a kept day walks the list from its tail with a single
// compare-and-shift step per cycle. A readout reads each entry from the RAM, then
// loads it into the output register. in_ready_o is high only when idle.
// A finished result waits in the output register while out_ready_i is low; the
// readout holds until it is taken. Reset empties the list, sets the day count
// to 1, start_day to 0 and score_threshold to 0.05. The RAM needs no clearing.
module thresholded_top_k_tracker
  import ttkt_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 8,
  parameter int unsigned MAX_DAYS   = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DAY_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SCORE_W-1:0]   score_i,
  input  logic                 final_day_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RANK_W-1:0]    rank_o,
  output logic [OFF_W-1:0]     offset_days_o,
  output logic [DAY_W-1:0]     event_day_o,
  output logic [SCORE_W-1:0]   entry_score_o,
  output logic                 entry_valid_o,
  output logic [FOUND_W-1:0]   found_count_o,
  output logic                 last_entry_o
);

  localparam int unsigned IDXW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned DAYW = $clog2(MAX_DAYS + 2);
  localparam logic [IDXW-1:0] LAST_POS = IDXW'(LIST_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMPTY
  } state_e;

  state_e state_q, state_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [DAYW-1:0]    day_q, day_d;
  logic [IDXW-1:0]    idx_q, idx_d;
  logic [SCORE_W-1:0] sc_q, sc_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               fin_q, fin_d;
  logic [DAY_W-1:0]   start_day_q, start_day_d;
  logic [SCORE_W-1:0] thr_q, thr_d;

  logic               out_valid_q, out_valid_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [OFF_W-1:0]   out_off_q, out_off_d;
  logic [DAY_W-1:0]   event_q, event_d;
  logic [SCORE_W-1:0] out_sc_q, out_sc_d;
  logic               ent_valid_q, ent_valid_d;
  logic [FOUND_W-1:0] found_q, found_d;
  logic               last_q, last_d;

  logic               ram_we;
  logic [IDXW-1:0]    ram_waddr;
  entry_t             ram_wdata;
  logic [IDXW-1:0]    ram_raddr;
  entry_t             ram_rdata;

  logic               in_accept;
  logic               in_range;
  logic               keep;
  logic               beats;
  logic               out_free;
  logic [IDXW-1:0]    tail_idx;
  entry_t             new_entry;
  state_e             done_state;

  ttkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_range   = (day_q <= DAYW'(MAX_DAYS));
  assign keep       = in_range && (score_i >= thr_q);
  assign beats      = (sc_q > ram_rdata.score);
  assign out_free   = !out_valid_q || out_ready_i;
  assign tail_idx   = IDXW'(cnt_q - CNTW'(1));
  assign new_entry  = '{score: sc_q, offset: off_q};
  assign done_state = fin_q ? S_EMIT_RD : S_IDLE;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    day_d       = day_q;
    idx_d       = idx_q;
    sc_d        = sc_q;
    off_d       = off_q;
    fin_d       = fin_q;
    start_day_d = start_day_q;
    thr_d       = thr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rank_d      = rank_q;
    out_off_d   = out_off_q;
    event_d     = event_q;
    out_sc_d    = out_sc_q;
    ent_valid_d = ent_valid_q;
    found_d     = found_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = IDXW'(idx_q + IDXW'(1));
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_DAY: start_day_d = cfg_wdata_i;
        CFG_THRESHOLD: thr_d = cfg_wdata_i[SCORE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        // Prefetch the tail entry so the scan can compare in its first cycle.
        ram_raddr = tail_idx;
        if (in_accept) begin
          sc_d  = score_i;
          off_d = OFF_W'(day_q);
          fin_d = final_day_i;
          if (in_range) begin
            day_d = DAYW'(day_q + DAYW'(1));
          end
          if (keep) begin
            if (cnt_q == '0) begin
              idx_d   = '0;
              state_d = S_PUT;
            end else begin
              idx_d   = tail_idx;
              state_d = S_SCAN;
            end
          end else if (final_day_i) begin
            idx_d   = '0;
            state_d = (cnt_q == '0) ? S_EMPTY : S_EMIT_RD;
          end
        end
      end
      S_SCAN: begin
        // Compare against entry idx while the entry above it is being read.
        ram_raddr = IDXW'(idx_q - IDXW'(1));
        if (beats) begin
          // Shift the entry down one place; the last one falls off a full list.
          ram_we = (idx_q != LAST_POS);
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d = IDXW'(idx_q - IDXW'(1));
          end
        end else begin
          if (idx_q != LAST_POS) begin
            ram_we    = 1'b1;
            ram_wdata = new_entry;
            if (cnt_q != CNTW'(LIST_DEPTH)) begin
              cnt_d = CNTW'(cnt_q + CNTW'(1));
            end
          end
          idx_d   = '0;
          state_d = done_state;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_entry;
        if (cnt_q != CNTW'(LIST_DEPTH)) begin
          cnt_d = CNTW'(cnt_q + CNTW'(1));
        end
        idx_d   = '0;
        state_d = done_state;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rank_d      = RANK_W'(idx_q);
          out_off_d   = ram_rdata.offset;
          event_d     = DAY_W'(start_day_q + {DAY_W'(ram_rdata.offset), FRAC_W'(0)});
          out_sc_d    = ram_rdata.score;
          ent_valid_d = 1'b1;
          found_d     = FOUND_W'(cnt_q);
          last_d      = (idx_q == tail_idx);
          if (idx_q == tail_idx) begin
            cnt_d   = '0;
            day_d   = DAYW'(1);
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = IDXW'(idx_q + IDXW'(1));
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rank_d      = '0;
          out_off_d   = '0;
          event_d     = '0;
          out_sc_d    = '0;
          ent_valid_d = 1'b0;
          found_d     = '0;
          last_d      = 1'b1;
          day_d       = DAYW'(1);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      day_q       <= DAYW'(1);
      idx_q       <= '0;
      fin_q       <= 1'b0;
      start_day_q <= '0;
      thr_q       <= THRESH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      day_q       <= day_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      start_day_q <= start_day_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q        <= sc_d;
    off_q       <= off_d;
    rank_q      <= rank_d;
    out_off_q   <= out_off_d;
    event_q     <= event_d;
    out_sc_q    <= out_sc_d;
    ent_valid_q <= ent_valid_d;
    found_q     <= found_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign rank_o        = rank_q;
  assign offset_days_o = out_off_q;
  assign event_day_o   = event_q;
  assign entry_score_o = out_sc_q;
  assign entry_valid_o = ent_valid_q;
  assign found_count_o = found_q;
  assign last_entry_o  = last_q;

endmodule

// File: rtl/ttkt_checker.sv
// Port-level checks for the thresholded top-K tracker, bound to its top level.
// Depends on ttkt_pkg for field widths.
module ttkt_checker
  import ttkt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               final_day_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [RANK_W-1:0]  rank_o,
  input logic [OFF_W-1:0]   offset_days_o,
  input logic [DAY_W-1:0]   event_day_o,
  input logic [SCORE_W-1:0] entry_score_o,
  input logic               entry_valid_o,
  input logic [FOUND_W-1:0] found_count_o,
  input logic               last_entry_o
);

  // A stalled result must hold still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rank_o) &&
      $stable(offset_days_o) && $stable(event_day_o) && $stable(entry_score_o) &&
      $stable(last_entry_o))
    else $error("result changed while stalled");

  // The empty marker is a lone result with nothing in the list.
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_entry_o && found_count_o == '0 &&
      rank_o == '0 && offset_days_o == '0 && event_day_o == '0)
    else $error("malformed empty-list marker");

  // The last real entry of a readout carries the rank just below the count.
  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o && last_entry_o |->
      rank_o == RANK_W'(found_count_o - FOUND_W'(1)))
    else $error("last entry rank does not match found count");

  // A real entry never reports an empty list.
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> found_count_o != '0)
    else $error("real entry with zero found count");

  // After the final item of a scan the block is busy with its readout.
  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_day_i |=> !in_ready_o)
    else $error("input ready right after final item");

endmodule

bind thresholded_top_k_tracker ttkt_checker u_ttkt_checker (.*);
